>>> rtl/ocp_pkg.sv
`default_nettype none
package ocp_pkg;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_ORB,
        ST_RED,
        ST_CORD,
        ST_GX,
        ST_GY,
        ST_MH,
        ST_MV,
        ST_MX,
        ST_MZ,
        ST_OUT
    } t_state;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_MIN_DIST    = 2'd0,
        CFG_MAX_DIST    = 2'd1,
        CFG_ZOOM_GAIN   = 2'd2,
        CFG_ROTATE_GAIN = 2'd3
    } t_cfg_index;

    localparam int                 AtanLen    = 30;
    localparam logic        [32:0] Deg360     = 33'd23592960;
    localparam logic signed [26:0] Deg360S    = 27'sd23592960;
    localparam logic signed [26:0] Deg180S    = 27'sd11796480;
    localparam logic signed [26:0] Deg90S     = 27'sd5898240;
    localparam logic signed [35:0] OneQ30     = 36'sd1073741824;
    localparam logic signed [32:0] InvGainQ30 = 33'sd652032875;
    localparam logic signed [65:0] HalfQ30    = 66'sd536870912;
    localparam logic signed [31:0] HeightOne  = 32'sd65536;

    // arctangent of 2^-i in degrees, Q16.16
    function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
        logic signed [31:0] v;
        unique case (i)
            5'd0:  v = 32'sd2949120;
            5'd1:  v = 32'sd1740967;
            5'd2:  v = 32'sd919879;
            5'd3:  v = 32'sd466945;
            5'd4:  v = 32'sd234379;
            5'd5:  v = 32'sd117304;
            5'd6:  v = 32'sd58666;
            5'd7:  v = 32'sd29335;
            5'd8:  v = 32'sd14668;
            5'd9:  v = 32'sd7334;
            5'd10: v = 32'sd3667;
            5'd11: v = 32'sd1833;
            5'd12: v = 32'sd917;
            5'd13: v = 32'sd458;
            5'd14: v = 32'sd229;
            5'd15: v = 32'sd115;
            5'd16: v = 32'sd57;
            5'd17: v = 32'sd29;
            5'd18: v = 32'sd14;
            5'd19: v = 32'sd7;
            5'd20: v = 32'sd4;
            5'd21: v = 32'sd2;
            5'd22: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // saturate to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -36'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/orbit_camera_position.sv
// orbit_camera_position: third-person orbit camera about a followed object
//
// input channel: i_in_valid / o_in_stall carry zoom step, pointer position
// and the object's position and heading; a transfer happens when valid is
// high and stall is low. The distance and pitch update at that transfer;
// the orbit angle updates after its wrap. Output channel: o_out_valid /
// i_out_stall carry camera x, height and z, one result per input item.
// config channel: i_cfg_valid / o_cfg_ready with i_cfg_index, i_cfg_data;
// ready is always high, write only while the block is idle.
//
// After the input transfer the block runs one orbit wrap, two angle
// reductions, two CORDIC runs of CORDIC_STEPS iterations (at most 30) and
// eight products (four gain corrections, four scalings) through one shared
// 33x33 multiplier, then raises o_out_valid. One item is in flight at a
// time; o_in_stall stays high from the input transfer until the result
// is taken.
// reset (i_rst_n low, synchronous) restores the register and state defaults
// and empties the block. While the receiver stalls, the result holds steady.
`default_nettype none
module orbit_camera_position
    import ocp_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic        [1:0]  i_cfg_index,
    input  wire logic        [31:0] i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [7:0]  i_zoom_step,
    input  wire logic        [11:0] i_pointer_x,
    input  wire logic        [11:0] i_pointer_y,
    input  wire logic signed [31:0] i_target_x,
    input  wire logic signed [31:0] i_target_heading,
    input  wire logic signed [31:0] i_target_z,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_camera_x,
    output logic signed [31:0]      o_camera_height,
    output logic signed [31:0]      o_camera_z
);

    localparam int StepsEff = (CORDIC_STEPS > AtanLen) ? AtanLen : CORDIC_STEPS;
    localparam logic [4:0] LastIter = 5'(StepsEff - 1);

    t_state r_state, n_state;

    // configuration
    logic [30:0] r_min_dist, r_max_dist;
    logic [15:0] r_zoom_gain, r_rot_gain;

    // camera state
    logic signed [31:0] r_dist, r_pitch, r_orbit;
    logic [11:0]        r_prev_x, r_prev_y;

    // latched item
    logic signed [31:0] r_tx, r_th, r_tz;

    // reducer
    logic [32:0] r_red_mag;
    logic        r_red_neg;
    logic [2:0]  r_red_k;

    // cordic
    logic signed [35:0] r_cx, r_cy;
    logic signed [31:0] r_cz;
    logic [4:0]         r_iter;
    logic               r_neg_cos;
    logic               r_second;

    // multiplier and results
    logic               r_half;
    logic signed [65:0] r_prod;
    logic signed [32:0] r_sin, r_cos;
    logic signed [31:0] r_hor;
    logic signed [31:0] r_cam_x, r_cam_h, r_cam_z;

    logic in_xfer, out_xfer, cfg_xfer;

    // handshake outputs
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_out_valid = (r_state == ST_OUT);
        o_cfg_ready = 1'b1;
    end

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = o_out_valid && !i_out_stall;
    assign cfg_xfer = i_cfg_valid && o_cfg_ready;

    assign o_camera_x      = r_cam_x;
    assign o_camera_height = r_cam_h;
    assign o_camera_z      = r_cam_z;

    // item update at the input transfer
    logic signed [24:0] zoom_prod;
    logic signed [33:0] d_raw, d_clamp;
    logic signed [12:0] dy, dx;
    logic signed [29:0] dy_prod, dx_prod;
    logic signed [35:0] pitch_sum;
    logic signed [31:0] pitch_new;
    logic signed [32:0] orbit_pre;

    always_comb begin
        zoom_prod = i_zoom_step * $signed({1'b0, r_zoom_gain});
        d_raw     = 34'(r_dist) - 34'(zoom_prod);
        d_clamp   = d_raw;
        if (d_clamp < $signed({3'b0, r_min_dist})) begin
            d_clamp = $signed({3'b0, r_min_dist});
        end
        if (d_clamp > $signed({3'b0, r_max_dist})) begin
            d_clamp = $signed({3'b0, r_max_dist});
        end
        dy        = $signed({1'b0, i_pointer_y}) - $signed({1'b0, r_prev_y});
        dx        = $signed({1'b0, i_pointer_x}) - $signed({1'b0, r_prev_x});
        dy_prod   = dy * $signed({1'b0, r_rot_gain});
        dx_prod   = dx * $signed({1'b0, r_rot_gain});
        pitch_sum = 36'(r_pitch) + 36'(dy_prod);
        pitch_new = sat32(pitch_sum);
        orbit_pre = 33'(r_orbit) - 33'(dx_prod);
    end

    // reducer step and signed remainder
    logic [32:0]        red_sub;
    logic [32:0]        red_next;
    logic signed [26:0] red_rem;
    logic signed [26:0] fold_a, fold_b;
    logic               fold_neg;
    logic signed [32:0] theta;

    always_comb begin
        red_sub  = Deg360 << r_red_k;
        red_next = (r_red_mag >= red_sub) ? (r_red_mag - red_sub) : r_red_mag;
        red_rem  = r_red_neg ? -$signed({1'b0, red_next[25:0]})
                             : $signed({1'b0, red_next[25:0]});
        fold_a   = red_rem;
        if (fold_a >= Deg180S) begin
            fold_a = fold_a - Deg360S;
        end
        if (fold_a < -Deg180S) begin
            fold_a = fold_a + Deg360S;
        end
        fold_neg = 1'b0;
        fold_b   = fold_a;
        if (fold_a > Deg90S) begin
            fold_b   = Deg180S - fold_a;
            fold_neg = 1'b1;
        end else if (fold_a < -Deg90S) begin
            fold_b   = -Deg180S - fold_a;
            fold_neg = 1'b1;
        end
        theta = 33'(r_th) + 33'(r_orbit);
    end

    // cordic micro-rotation
    logic signed [35:0] x_sh, y_sh;
    logic signed [31:0] at;

    always_comb begin
        x_sh = r_cx >>> r_iter;
        y_sh = r_cy >>> r_iter;
        at   = atan_deg(r_iter);
    end

    // shared multiplier operand select
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [65:0] rnd;
    logic signed [35:0] rq;
    logic signed [32:0] gq;

    always_comb begin
        unique case (r_state)
            ST_GX: begin
                mul_a = r_cx[32:0];
                mul_b = InvGainQ30;
            end
            ST_GY: begin
                mul_a = r_cy[32:0];
                mul_b = InvGainQ30;
            end
            ST_MH: begin
                mul_a = 33'(r_dist);
                mul_b = r_cos;
            end
            ST_MV: begin
                mul_a = 33'(r_dist);
                mul_b = r_sin;
            end
            ST_MX: begin
                mul_a = 33'(r_hor);
                mul_b = r_sin;
            end
            ST_MZ: begin
                mul_a = 33'(r_hor);
                mul_b = r_cos;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
        rnd   = r_prod + HalfQ30;
        rq    = rnd[65:30];
        gq    = r_prod[62:30];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (in_xfer) n_state = ST_RED_ORB;
            ST_RED_ORB: if (r_red_k == 3'd0) n_state = ST_RED;
            ST_RED:     if (r_red_k == 3'd0) n_state = ST_CORD;
            ST_CORD:    if (r_iter == LastIter) n_state = ST_GX;
            ST_GX:      if (r_half) n_state = ST_GY;
            ST_GY:      if (r_half) n_state = r_second ? ST_MX : ST_MH;
            ST_MH:      if (r_half) n_state = ST_MV;
            ST_MV:      if (r_half) n_state = ST_RED;
            ST_MX:      if (r_half) n_state = ST_MZ;
            ST_MZ:      if (r_half) n_state = ST_OUT;
            ST_OUT:     if (out_xfer) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_min_dist  <= 31'd655360;
            r_max_dist  <= 31'd13107200;
            r_zoom_gain <= 16'd19661;
            r_rot_gain  <= 16'd19661;
            r_dist      <= 32'sd1310720;
            r_pitch     <= 32'sd1310720;
            r_orbit     <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_half      <= 1'b0;
            r_second    <= 1'b0;
            r_red_k     <= '0;
            r_iter      <= '0;
        end else begin
            r_state <= n_state;
            // configuration writes
            if (cfg_xfer) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_MIN_DIST:    r_min_dist  <= i_cfg_data[30:0];
                    CFG_MAX_DIST:    r_max_dist  <= i_cfg_data[30:0];
                    CFG_ZOOM_GAIN:   r_zoom_gain <= i_cfg_data[15:0];
                    CFG_ROTATE_GAIN: r_rot_gain  <= i_cfg_data[15:0];
                    default:         r_rot_gain  <= r_rot_gain;
                endcase
            end
            // state update at input transfer
            if (in_xfer) begin
                r_dist   <= d_clamp[31:0];
                r_pitch  <= pitch_new;
                r_prev_x <= i_pointer_x;
                r_prev_y <= i_pointer_y;
                r_red_k  <= 3'd7;
                r_second <= 1'b0;
            end
            // reducer counter
            if (r_state == ST_RED_ORB || r_state == ST_RED) begin
                r_red_k <= r_red_k - 3'd1;
                if (r_state == ST_RED_ORB && r_red_k == 3'd0) begin
                    r_orbit <= 32'(red_rem);
                    r_red_k <= 3'd7;
                end
                if (r_state == ST_RED && r_red_k == 3'd0) begin
                    r_iter <= '0;
                end
            end
            if (r_state == ST_CORD) begin
                r_iter <= r_iter + 5'd1;
            end
            // each product alternates between capture and use
            if (r_state == ST_GX || r_state == ST_GY || r_state == ST_MH ||
                r_state == ST_MV || r_state == ST_MX || r_state == ST_MZ) begin
                r_half <= !r_half;
            end
            if (r_state == ST_MV && r_half) begin
                r_second <= 1'b1;
                r_red_k  <= 3'd7;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_tx      <= i_target_x;
            r_th      <= i_target_heading;
            r_tz      <= i_target_z;
            r_red_neg <= orbit_pre[32];
            r_red_mag <= orbit_pre[32] ? 33'(-orbit_pre) : 33'(orbit_pre);
        end
        // reducer iteration
        if (r_state == ST_RED_ORB || r_state == ST_RED) begin
            r_red_mag <= red_next;
        end
        if (r_state == ST_RED_ORB && r_red_k == 3'd0) begin
            r_red_neg <= r_pitch[31];
            r_red_mag <= r_pitch[31] ? 33'(-33'(r_pitch)) : 33'(r_pitch);
        end
        // cordic load
        if (r_state == ST_RED && r_red_k == 3'd0) begin
            r_cx      <= OneQ30;
            r_cy      <= '0;
            r_cz      <= 32'(fold_b);
            r_neg_cos <= fold_neg;
        end
        // cordic rotation
        if (r_state == ST_CORD) begin
            if (!r_cz[31]) begin
                r_cx <= r_cx - y_sh;
                r_cy <= r_cy + x_sh;
                r_cz <= r_cz - at;
            end else begin
                r_cx <= r_cx + y_sh;
                r_cy <= r_cy - x_sh;
                r_cz <= r_cz + at;
            end
        end
        // product capture and use
        if (!r_half) begin
            r_prod <= mul_p;
        end else begin
            unique case (r_state)
                ST_GX: r_cos <= r_neg_cos ? -gq : gq;
                ST_GY: r_sin <= gq;
                ST_MH: r_hor <= sat32(rq);
                ST_MV: r_cam_h <= rq[35] ? HeightOne : sat32(rq);
                ST_MX: r_cam_x <= sat32(36'(r_tx) - rq);
                ST_MZ: r_cam_z <= sat32(36'(r_tz) - rq);
                default: r_prod <= r_prod;
            endcase
        end
        // theta reduction load
        if (r_state == ST_MV && r_half) begin
            r_red_neg <= theta[32];
            r_red_mag <= theta[32] ? 33'(-theta) : 33'(theta);
        end
    end

    // checks
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("result pending while input open");

    a_out_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |=> !o_out_valid)
        else $error("result repeated after transfer");

    a_height_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_camera_height[31])
        else $error("negative camera height");

    a_iter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CORD) |-> (r_iter <= LastIter))
        else $error("cordic iteration out of range");

endmodule
`default_nettype wire
